// ===== design/lpg_pkg.sv =====
// Line pixel generator package: coordinate widths, queue depth and the line
// descriptor passed from the front end to the pixel stepper.
// No dependencies.
`default_nettype none

package lpg_pkg;

   localparam int COORD_W     = 6;
   localparam int COLOUR_W    = 32;
   localparam int CANVAS_SIZE = 64;
   localparam int QUEUE_DEPTH = 2;

   typedef logic [COORD_W-1:0]  coord_type;
   typedef logic [COLOUR_W-1:0] colour_type;

   typedef struct packed {
      logic              y_major;
      coord_type         m_start;
      coord_type         n_start;
      coord_type         m_end;
      coord_type         span;
      logic signed [COORD_W:0] n_delta;
      colour_type        colour;
   } line_desc_type;

endpackage

`default_nettype wire

// ===== design/lpg_front.sv =====
// Front end of the line pixel generator: clamps the endpoints, picks the
// major axis and orders the endpoints into a line descriptor.
// Depends on lpg_pkg.
`default_nettype none

module lpg_front #(
   parameter int CANVAS_SIZE = lpg_pkg::CANVAS_SIZE
) (
   input  wire lpg_pkg::coord_type      start_x,
   input  wire lpg_pkg::coord_type      start_y,
   input  wire lpg_pkg::coord_type      end_x,
   input  wire lpg_pkg::coord_type      end_y,
   input  wire lpg_pkg::colour_type     colour,
   output lpg_pkg::line_desc_type       desc
);
   import lpg_pkg::*;

   localparam coord_type MAX_COORD = COORD_W'(CANVAS_SIZE - 1);

   function automatic coord_type clamp_coord(input coord_type v);
      coord_type c;
      c = (v > MAX_COORD) ? MAX_COORD : v;
      return c;
   endfunction

   coord_type ax, ay, bx, by;
   coord_type dx, dy;
   coord_type ma, na, mb, nb;
   coord_type m0, n0, m1, n1;
   logic      y_major;

   always_comb begin
      ax = clamp_coord(start_x);
      ay = clamp_coord(start_y);
      bx = clamp_coord(end_x);
      by = clamp_coord(end_y);
      dx = (ax > bx) ? ax - bx : bx - ax;
      dy = (ay > by) ? ay - by : by - ay;
      y_major = dx < dy;
      if (y_major) begin
         ma = ay; na = ax; mb = by; nb = bx;
      end else begin
         ma = ax; na = ay; mb = bx; nb = by;
      end
      if (ma > mb) begin
         m0 = mb; n0 = nb; m1 = ma; n1 = na;
      end else begin
         m0 = ma; n0 = na; m1 = mb; n1 = nb;
      end
      desc.y_major = y_major;
      desc.m_start = m0;
      desc.n_start = n0;
      desc.m_end   = m1;
      desc.span    = m1 - m0;
      desc.n_delta = $signed({1'b0, n1}) - $signed({1'b0, n0});
      desc.colour  = colour;
   end

endmodule

`default_nettype wire

// ===== design/lpg_queue.sv =====
// Short descriptor queue between the front end and the pixel stepper.
// Depends on lpg_pkg.
`default_nettype none

module lpg_queue #(
   parameter int DEPTH = lpg_pkg::QUEUE_DEPTH
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         push,
   input  wire lpg_pkg::line_desc_type push_desc,
   input  wire                         pop,
   output lpg_pkg::line_desc_type      head_desc,
   output logic                        full,
   output logic                        empty
);
   import lpg_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   line_desc_type    mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   always_comb begin
      full      = count_ff == CNT_W'(DEPTH);
      empty     = count_ff == '0;
      do_push   = push && !full;
      do_pop    = pop && !empty;
      head_desc = mem_ff[rd_ptr_ff];
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

`default_nettype wire

// ===== design/lpg_back.sv =====
// Pixel stepper of the line pixel generator: walks the major axis one pixel
// a cycle within a line, stepping the minor axis with a remainder accumulator.
// Depends on lpg_pkg.
`default_nettype none

module lpg_back (
   input  wire                         clock,
   input  wire                         reset,
   input  wire lpg_pkg::line_desc_type head_desc,
   input  wire                         q_empty,
   output logic                        pop,
   output logic                        rsp_valid,
   output lpg_pkg::coord_type          rsp_pixel_x,
   output lpg_pkg::coord_type          rsp_pixel_y,
   output lpg_pkg::colour_type         rsp_pixel_colour,
   output logic                        rsp_last_pixel
);
   import lpg_pkg::*;

   typedef enum logic {ST_IDLE, ST_RUN} state_type;

   state_type   state_ff, state_in;
   logic        y_major_ff, y_major_in;
   coord_type   m_ff, m_in;
   coord_type   n_ff, n_in;
   coord_type   m_end_ff, m_end_in;
   coord_type   span_ff, span_in;
   logic signed [COORD_W:0]   n_delta_ff, n_delta_in;
   logic signed [COORD_W+1:0] rem_ff, rem_in;
   colour_type  colour_ff, colour_in;
   logic        valid_ff, valid_in;
   coord_type   px_ff, px_in;
   coord_type   py_ff, py_in;
   colour_type  pcol_ff, pcol_in;
   logic        plast_ff, plast_in;

   logic signed [COORD_W+1:0] rem_sum;
   logic signed [COORD_W+1:0] span_s;
   logic                      at_end;

   always_comb begin
      pop     = (state_ff == ST_IDLE) && !q_empty;
      rem_sum = rem_ff + {n_delta_ff[COORD_W], n_delta_ff};
      span_s  = $signed({2'b00, span_ff});
      at_end  = m_ff == m_end_ff;

      state_in   = state_ff;
      y_major_in = y_major_ff;
      m_in       = m_ff;
      n_in       = n_ff;
      m_end_in   = m_end_ff;
      span_in    = span_ff;
      n_delta_in = n_delta_ff;
      rem_in     = rem_ff;
      colour_in  = colour_ff;
      valid_in   = 1'b0;
      px_in      = px_ff;
      py_in      = py_ff;
      pcol_in    = pcol_ff;
      plast_in   = plast_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               y_major_in = head_desc.y_major;
               m_in       = head_desc.m_start;
               n_in       = head_desc.n_start;
               m_end_in   = head_desc.m_end;
               span_in    = head_desc.span;
               n_delta_in = head_desc.n_delta;
               rem_in     = '0;
               colour_in  = head_desc.colour;
               state_in   = ST_RUN;
            end
         end
         ST_RUN: begin
            valid_in = 1'b1;
            px_in    = y_major_ff ? n_ff : m_ff;
            py_in    = y_major_ff ? m_ff : n_ff;
            pcol_in  = colour_ff;
            plast_in = at_end;
            if (at_end) begin
               state_in = ST_IDLE;
            end else begin
               m_in = m_ff + 1'b1;
               priority if (rem_sum >= span_s) begin
                  n_in   = n_ff + 1'b1;
                  rem_in = rem_sum - span_s;
               end else if (rem_sum < 0) begin
                  n_in   = n_ff - 1'b1;
                  rem_in = rem_sum + span_s;
               end else begin
                  rem_in = rem_sum;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      y_major_ff <= y_major_in;
      m_ff       <= m_in;
      n_ff       <= n_in;
      m_end_ff   <= m_end_in;
      span_ff    <= span_in;
      n_delta_ff <= n_delta_in;
      rem_ff     <= rem_in;
      colour_ff  <= colour_in;
      px_ff      <= px_in;
      py_ff      <= py_in;
      pcol_ff    <= pcol_in;
      plast_ff   <= plast_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_pixel_x      = px_ff;
   assign rsp_pixel_y      = py_ff;
   assign rsp_pixel_colour = pcol_ff;
   assign rsp_last_pixel   = plast_ff;

endmodule

`default_nettype wire

// ===== design/line_pixel_generator_top.sv =====
// Line pixel generator top level: front end, descriptor queue, pixel stepper.
// Depends on lpg_pkg, lpg_front, lpg_queue and lpg_back.
//
// Usage: raise start with two endpoints and a colour on the req_ ports; the
// request is taken at a clock edge where start is high and busy is low.
// busy is high only while the descriptor queue is full, so requests may be
// issued while a line is still being drawn.
// Each pixel appears on the rsp_ ports for one cycle with rsp_valid high;
// rsp_last_pixel marks the final pixel of a line. Pixels run with the
// major coordinate rising; the minor coordinate is the floored exact
// interpolation. Coordinates above CANVAS_SIZE-1 are clamped.
// A request reaches the rsp_ ports through the queue, the stepper's line
// registers and its pixel output registers. Pixel rate: one pixel a
// cycle while a line runs; a line of span S gives S+1 pixels, and the
// single pixel stepper idles between lines to load the next descriptor.
// Reset empties the queue and idles the stepper. The receiver cannot stall;
// results are never held.
`default_nettype none

module line_pixel_generator_top #(
   parameter int CANVAS_SIZE = lpg_pkg::CANVAS_SIZE,
   parameter int QUEUE_DEPTH = lpg_pkg::QUEUE_DEPTH
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     start,
   output logic                    busy,
   input  wire lpg_pkg::coord_type  req_start_x,
   input  wire lpg_pkg::coord_type  req_start_y,
   input  wire lpg_pkg::coord_type  req_end_x,
   input  wire lpg_pkg::coord_type  req_end_y,
   input  wire lpg_pkg::colour_type req_colour,
   output logic                    rsp_valid,
   output lpg_pkg::coord_type      rsp_pixel_x,
   output lpg_pkg::coord_type      rsp_pixel_y,
   output lpg_pkg::colour_type     rsp_pixel_colour,
   output logic                    rsp_last_pixel
);
   import lpg_pkg::*;

   line_desc_type front_desc;
   line_desc_type head_desc;
   logic          q_full;
   logic          q_empty;
   logic          q_pop;

   assign busy = q_full;

   lpg_front #(
      .CANVAS_SIZE(CANVAS_SIZE)
   ) u_front (
      .start_x (req_start_x),
      .start_y (req_start_y),
      .end_x   (req_end_x),
      .end_y   (req_end_y),
      .colour  (req_colour),
      .desc    (front_desc)
   );

   lpg_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (start),
      .push_desc (front_desc),
      .pop       (q_pop),
      .head_desc (head_desc),
      .full      (q_full),
      .empty     (q_empty)
   );

   lpg_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_desc        (head_desc),
      .q_empty          (q_empty),
      .pop              (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_pixel_x      (rsp_pixel_x),
      .rsp_pixel_y      (rsp_pixel_y),
      .rsp_pixel_colour (rsp_pixel_colour),
      .rsp_last_pixel   (rsp_last_pixel)
   );

endmodule

`default_nettype wire
